FILE: sv/d96r_pkg.sv
// d96r_pkg: shared types and constants for the decimal96 round unit.
// Holds operation codes, controller states and the command/status words
// passed between d96r_ctrl and d96r_dp. No dependencies.
package d96r_pkg;

  localparam int unsigned MagWidth   = 96;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned ScaleWidth = 5;
  localparam int unsigned KindWidth  = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_FLOOR    = 2'd0,
    KIND_ROUND    = 2'd1,
    KIND_TRUNCATE = 2'd2,
    KIND_NEGATE   = 2'd3
  } d96r_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADJ
  } d96r_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture a new input word
    logic div_step;   // divide the top magnitude word by ten, rotate
    logic last_word;  // this step finishes one full division by ten
    logic adjust;     // apply the rounding increment, fill the output register
  } d96r_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [ScaleWidth-1:0] scale;
    logic                  negate;
  } d96r_sts_t;

endpackage

FILE: sv/decimal96_round_unit.sv
// decimal96_round_unit: top level; floor, round, truncate or negate of a
// 96-bit decimal magnitude with a scale. Depends on d96r_pkg, d96r_ctrl
// and d96r_dp.
//
//   port group   dir  tdata / tuser
//   s_axis_*     in   tdata: mant_lo, mant_mid, mant_hi, scale, sign; tuser: kind
//   m_axis_*     out  tdata: res_lo, res_mid, res_hi, res_scale, res_sign
//
// From accept, the unit makes scale divisions by ten, each of which steps
// through the three 32-bit words in turn, one per step, through the single
// reciprocal multiplier in d96r_dp; then the division loop ends and the
// result is written to the output register. Negate makes no division.
// The next word is accepted in the cycle after the previous one reaches
// the output register, even while that register waits for m_axis_tready;
// a full output register holds the result step.
// Reset clears the controller and the output valid flag; no clearing pass.
module decimal96_round_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] mant_lo, [63:32] mant_mid, [95:64] mant_hi, [100:96] scale,
  // [101] sign, [103:102] zero
  input  logic [103:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] res_lo, [63:32] res_mid, [95:64] res_hi, [100:96] res_scale,
  // [101] res_sign, [103:102] zero
  output logic [103:0] m_axis_tdata
);
  import d96r_pkg::*;

  d96r_cmd_t             cmd;
  d96r_sts_t             sts;
  logic [MagWidth-1:0]   res_mag;
  logic [ScaleWidth-1:0] res_scale;
  logic                  res_sign;

  d96r_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  d96r_dp u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (s_axis_tuser),
    .in_mag_i    (s_axis_tdata[95:0]),
    .in_scale_i  (s_axis_tdata[100:96]),
    .in_sign_i   (s_axis_tdata[101]),
    .res_mag_o   (res_mag),
    .res_scale_o (res_scale),
    .res_sign_o  (res_sign)
  );

  assign m_axis_tdata = {2'b00, res_sign, res_scale, res_mag};

endmodule

FILE: sv/d96r_dp.sv
// d96r_dp: datapath of the decimal96 round unit. Holds the magnitude,
// divides it by ten one 32-bit word per step and forms the result.
// Depends on d96r_pkg; driven by d96r_ctrl.
module d96r_dp (
  input  logic                          clk_i,
  input  d96r_pkg::d96r_cmd_t           cmd_i,
  output d96r_pkg::d96r_sts_t           sts_o,
  input  logic [d96r_pkg::KindWidth-1:0] in_kind_i,
  input  logic [d96r_pkg::MagWidth-1:0]  in_mag_i,
  input  logic [d96r_pkg::ScaleWidth-1:0] in_scale_i,
  input  logic                          in_sign_i,
  output logic [d96r_pkg::MagWidth-1:0]  res_mag_o,
  output logic [d96r_pkg::ScaleWidth-1:0] res_scale_o,
  output logic                          res_sign_o
);
  import d96r_pkg::*;

  // 2^32 = 10 * WordQuot + WordRem
  localparam logic [31:0] WordQuot = 32'd429496729;
  localparam logic [32:0] WordRem  = 33'd6;
  // ceil(2^36 / 10); exact floor(y / 10) for y below 2^34
  localparam logic [65:0] RecipTen = 66'd6871947674;
  localparam int unsigned RecipShift = 36;

  logic [MagWidth-1:0]   mant_q, mant_d;
  logic [3:0]            rem_q, rem_d;
  logic [3:0]            first_q, first_d;
  logic                  sticky_q, sticky_d;
  logic [KindWidth-1:0]  kind_q;
  logic [ScaleWidth-1:0] scale_q;
  logic                  sign_q;
  logic [MagWidth-1:0]   res_mag_q;
  logic [ScaleWidth-1:0] res_scale_q;
  logic                  res_sign_q;

  logic [WordWidth-1:0] top_word;
  logic [32:0]          part;
  logic [65:0]          prod;
  logic [29:0]          part_quot;
  logic [32:0]          part_rem;
  logic [3:0]           digit;
  logic [WordWidth-1:0] word_quot;
  logic                 inc;

  // {rem, top} / 10 = rem * WordQuot + (rem * 6 + top) / 10
  always_comb begin
    top_word  = mant_q[MagWidth-1 -: WordWidth];
    part      = {1'b0, top_word} + 33'(rem_q) * WordRem;
    prod      = 66'(part) * RecipTen;
    part_quot = prod[RecipShift +: 30];
    part_rem  = part - 33'(part_quot) * 33'd10;
    digit     = part_rem[3:0];
    word_quot = 32'(rem_q) * WordQuot + 32'(part_quot);
  end

  always_comb begin
    case (kind_q)
      KIND_FLOOR: inc = sign_q & sticky_q;
      KIND_ROUND: inc = (first_q >= 4'd5);
      default:    inc = 1'b0;
    endcase
  end

  always_comb begin
    mant_d   = mant_q;
    rem_d    = rem_q;
    first_d  = first_q;
    sticky_d = sticky_q;
    if (cmd_i.load) begin
      mant_d   = in_mag_i;
      rem_d    = '0;
      first_d  = '0;
      sticky_d = 1'b0;
    end else if (cmd_i.div_step) begin
      // rotate: after three steps the words are back in place
      mant_d = {mant_q[MagWidth-WordWidth-1:0], word_quot};
      if (cmd_i.last_word) begin
        rem_d    = '0;
        first_d  = digit;
        sticky_d = sticky_q | (digit != 4'd0);
      end else begin
        rem_d = digit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mant_q   <= mant_d;
    rem_q    <= rem_d;
    first_q  <= first_d;
    sticky_q <= sticky_d;
    if (cmd_i.load) begin
      kind_q  <= in_kind_i;
      scale_q <= in_scale_i;
      sign_q  <= in_sign_i;
    end
    if (cmd_i.adjust) begin
      res_mag_q <= mant_q + MagWidth'(inc);
      if (kind_q == KIND_NEGATE) begin
        res_scale_q <= scale_q;
        res_sign_q  <= ~sign_q;
      end else begin
        res_scale_q <= '0;
        res_sign_q  <= sign_q;
      end
    end
  end

  assign sts_o.scale  = scale_q;
  assign sts_o.negate = (kind_q == KIND_NEGATE);
  assign res_mag_o    = res_mag_q;
  assign res_scale_o  = res_scale_q;
  assign res_sign_o   = res_sign_q;

endmodule

FILE: sv/d96r_ctrl.sv
// d96r_ctrl: controller of the decimal96 round unit. Sequences the
// word-wise divisions by ten and owns the output register's valid flag.
// Depends on d96r_pkg; drives d96r_dp.
module d96r_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  d96r_pkg::d96r_sts_t sts_i,
  output d96r_pkg::d96r_cmd_t cmd_o
);
  import d96r_pkg::*;

  d96r_state_e           state_q, state_d;
  logic [1:0]            word_q, word_d;
  logic [ScaleWidth-1:0] div_cnt_q, div_cnt_d;
  logic                  out_full_q, out_full_d;
  logic                  out_free;

  assign out_free = ~out_full_q | out_ready_i;

  always_comb begin
    state_d    = state_q;
    word_d     = word_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          word_d     = '0;
          div_cnt_d  = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (word_q == 2'd0 && (sts_i.negate || div_cnt_q == sts_i.scale)) begin
          state_d = ST_ADJ;
        end else begin
          cmd_o.div_step  = 1'b1;
          cmd_o.last_word = (word_q == 2'd2);
          if (word_q == 2'd2) begin
            word_d    = '0;
            div_cnt_d = div_cnt_q + 1'b1;
          end else begin
            word_d = word_q + 1'b1;
          end
        end
      end
      ST_ADJ: begin
        // wait until the output register is free
        if (out_free) begin
          cmd_o.adjust = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_d = out_full_q;
    if (cmd_o.adjust) begin
      out_full_d = 1'b1;
    end else if (out_ready_i) begin
      out_full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      word_q     <= '0;
      div_cnt_q  <= '0;
      out_full_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_q     <= word_d;
      div_cnt_q  <= div_cnt_d;
      out_full_q <= out_full_d;
    end
  end

  assign out_valid_o = out_full_q;

  a_adjust_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.adjust |-> (!out_full_q || out_ready_i))
    else $error("result written over an untaken word");

  a_adjust_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.adjust |=> out_full_q)
    else $error("output valid not raised after adjust");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |-> (div_cnt_q < sts_i.scale && !sts_i.negate))
    else $error("division step beyond the scale");

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_q != 2'd3)
    else $error("word index out of range");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DIV && word_q == 2'd0 && div_cnt_q == '0))
    else $error("division sequence not restarted on load");

endmodule

FILE: test/tb.sv
// tb: self-checking testbench for decimal96_round_unit (floor, round, truncate, negate).
// Depends on d96r_pkg and the decimal96_round_unit RTL. Queue-fed stream driver,
// a stream monitor checked against an in-bench predictor, random idling on both sides.
`timescale 1ns / 100ps

module tb;
  import d96r_pkg::*;

  localparam int unsigned RandomWords = 1000;
  localparam int unsigned StallLimit  = 3000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 120;

  typedef struct packed {
    d96r_kind_e  kind;
    logic [95:0] mant;
    logic [4:0]  scale;
    logic        sign;
  } dec_word_t;

  typedef struct packed {
    logic [95:0] mag;
    logic [4:0]  scale;
    logic        sign;
  } dec_result_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;

  dec_word_t   words_to_send[$];
  dec_result_t expected_results[$];
  dec_word_t   word_on_bus;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned next_long_hold = 150;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          timed_out = 1'b0;

  decimal96_round_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Floor, round, truncate or negate one decimal word.
  function automatic dec_result_t round_decimal(dec_word_t w);
    dec_result_t r;
    logic [3:0]  digit;
    bit          lost_nonzero;
    int          i;
    r.mag = w.mant;
    r.sign = w.sign;
    r.scale = '0;
    digit = '0;
    lost_nonzero = 1'b0;
    if (w.kind == KIND_NEGATE) begin
      r.sign = ~w.sign;
      r.scale = w.scale;
    end else begin
      for (i = 0; i < int'(w.scale); i++) begin
        digit = 4'(r.mag % 96'd10);
        r.mag = r.mag / 96'd10;
        if (digit != 0) lost_nonzero = 1'b1;
      end
      if (w.kind == KIND_FLOOR && w.sign && lost_nonzero) r.mag = r.mag + 96'd1;
      if (w.kind == KIND_ROUND && digit >= 4'd5) r.mag = r.mag + 96'd1;
    end
    return r;
  endfunction

  function automatic logic [95:0] pow10(int unsigned n);
    logic [95:0] p;
    int unsigned i;
    p = 96'd1;
    for (i = 0; i < n; i++) p = p * 96'd10;
    return p;
  endfunction

  function automatic logic [95:0] rand96();
    return {$urandom, $urandom, $urandom};
  endfunction

  // Mostly short gaps, a few long ones; none while quiet.
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic queue_word(d96r_kind_e kind, logic [95:0] mant, logic [4:0] scale,
                            logic sign);
    dec_word_t w;
    w.kind = kind;
    w.mant = mant;
    w.scale = scale;
    w.sign = sign;
    words_to_send.push_back(w);
  endtask

  task automatic check_field(string name, logic [95:0] exp_v, logic [95:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Driver: hold the word until accepted, then advance to the next after a gap.
  always @(posedge clk_i or negedge rst_ni) begin
    bit busy;
    bit valid_nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
    end else begin
      busy = s_axis_tvalid;
      valid_nxt = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(round_decimal(word_on_bus));
        words_sent++;
        if (words_sent % 64 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        busy = 1'b0;
      end
      if (!busy) begin
        valid_nxt = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (words_to_send.size() > 0) begin
          word_on_bus = words_to_send.pop_front();
          s_axis_tdata <= {2'b00, word_on_bus.sign, word_on_bus.scale, word_on_bus.mant};
          s_axis_tuser <= word_on_bus.kind;
          valid_nxt = 1'b1;
          tx_gap = pick_gap(tx_quiet);
        end
      end
      s_axis_tvalid <= valid_nxt;
    end
  end

  // Receiver: random stalls, plus long hold-offs that back the block up.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_stall == 0 && results_seen >= next_long_hold) begin
        rx_stall = LongHold;
        next_long_hold = next_long_hold + 450;
      end else if (rx_stall == 0) begin
        rx_stall = pick_gap(rx_quiet);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result word with the oldest prediction.
  always @(posedge clk_i) begin
    dec_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (results_seen % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result word, expected none, actual %h", $time,
                 m_axis_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("res_lo", 96'(exp_r.mag[31:0]), 96'(m_axis_tdata[31:0]));
        check_field("res_mid", 96'(exp_r.mag[63:32]), 96'(m_axis_tdata[63:32]));
        check_field("res_hi", 96'(exp_r.mag[95:64]), 96'(m_axis_tdata[95:64]));
        check_field("res_scale", 96'(exp_r.scale), 96'(m_axis_tdata[100:96]));
        check_field("res_sign", 96'(exp_r.sign), 96'(m_axis_tdata[101]));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) timed_out = 1'b1;
    end
  end

  initial begin
    logic [95:0] p;
    logic [95:0] half;
    logic [95:0] tail;
    logic [95:0] mant;
    logic [4:0]  sc;
    int          k;
    int unsigned n;
    int unsigned sel;

    // Directed: extremes, every operation, half cases, negative zero, scale above range.
    for (k = 0; k < 4; k++) begin
      queue_word(d96r_kind_e'(k), '1, 5'd28, 1'b1);
      queue_word(d96r_kind_e'(k), '0, 5'd3, 1'b1);
      queue_word(d96r_kind_e'(k), '1, 5'd31, 1'b0);
    end
    queue_word(KIND_ROUND, 96'd25, 5'd1, 1'b0);
    queue_word(KIND_ROUND, 96'd25, 5'd1, 1'b1);
    queue_word(KIND_ROUND, 96'd149999, 5'd5, 1'b0);
    queue_word(KIND_FLOOR, 96'd25, 5'd1, 1'b1);
    queue_word(KIND_FLOOR, 96'd1000, 5'd3, 1'b1);
    queue_word(KIND_FLOOR, 96'd1001, 5'd3, 1'b1);
    queue_word(KIND_TRUNCATE, 96'd1999, 5'd3, 1'b1);
    queue_word(KIND_TRUNCATE, '1, 5'd0, 1'b0);
    queue_word(KIND_ROUND, 96'h1234_5678_9abc_def0_0fed_cba9, 5'd0, 1'b1);
    queue_word(KIND_ROUND, pow10(28) / 96'd2, 5'd28, 1'b0);

    for (n = 0; n < RandomWords; n++) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) sc = 5'($urandom_range(29, 31));
      else if (sel == 1) sc = '0;
      else sc = 5'($urandom_range(1, 28));
      sel = $urandom_range(0, 3);
      if (sel == 0 || sc > 5'd28) begin
        mant = rand96();
      end else if (sel == 1) begin
        mant = {64'd0, $urandom};
      end else begin
        // Build an integer part and a chosen fraction to hit rounding boundaries.
        p = pow10(sc);
        half = p / 96'd2;
        case ($urandom_range(0, 5))
          0: tail = '0;
          1: tail = half;
          2: tail = (half == 0) ? '0 : half - 96'd1;
          3: tail = (half + 96'd1 < p) ? half + 96'd1 : '0;
          4: tail = p - 96'd1;
          default: tail = rand96() % p;
        endcase
        mant = (rand96() % ('1 / p)) * p + tail;
      end
      queue_word(d96r_kind_e'($urandom_range(0, 3)), mant, sc, 1'($urandom_range(0, 1)));
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!timed_out && (words_to_send.size() != 0 || s_axis_tvalid ||
                          expected_results.size() != 0))
      @(posedge clk_i);
    if (!timed_out) repeat (DrainCycles) @(posedge clk_i);

    if (timed_out || mismatch_cnt != 0 || expected_results.size() != 0)
      $display("FAIL decimal96_round_unit");
    else
      $display("PASS decimal96_round_unit");
    $finish;
  end

endmodule
